// ===== src/dmic_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the direct-mapped instruction cache
// no dependencies

package dmic_pkg;

	localparam int LINE_COUNT     = 512;
	localparam int WORDS_PER_LINE = 8;

	localparam int INDEX_W  = $clog2(LINE_COUNT);
	localparam int WORD_W   = $clog2(WORDS_PER_LINE);
	localparam int OFFSET_W = WORD_W + 2;
	localparam int TAG_LSB  = 12;
	localparam int TAG_W    = 32 - TAG_LSB;

	localparam logic [31:0] MEM_MASK = 32'h1fff_fffc;

	// input item kinds
	localparam logic [1:0] KIND_FETCH     = 2'd0;
	localparam logic [1:0] KIND_FILL      = 2'd1;
	localparam logic [1:0] KIND_WRITEBACK = 2'd2;

	// result kinds
	localparam logic [1:0] RES_WORD     = 2'd0;
	localparam logic [1:0] RES_FILL_REQ = 2'd1;
	localparam logic [1:0] RES_READ_REQ = 2'd2;
	localparam logic [1:0] RES_WB_WORD  = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_FILL,
		ST_WB
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
	} meta_t;

	typedef logic [WORDS_PER_LINE-1:0][31:0] row_t;

	typedef struct packed {
		logic               rd_en;
		logic [INDEX_W-1:0] rd_idx;
		logic [INDEX_W-1:0] wr_idx;
		logic               meta_we;
		meta_t              meta_wdata;
		logic               data_clr;
		logic               data_we;
		logic [WORD_W-1:0]  data_word;
		logic [31:0]        data_wdata;
	} store_req_t;

	typedef struct packed {
		meta_t meta;
		row_t  row;
	} store_rsp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] address;
		logic [31:0] data;
		logic        hit;
		logic        last;
	} result_t;

	// memory address of a line from its tag and index
	function automatic logic [31:0] line_base(input logic [TAG_W-1:0] tag,
		input logic [INDEX_W-1:0] idx);
		logic [31:0] b;
		b = {tag, {TAG_LSB{1'b0}}} | (32'(idx) << OFFSET_W);
		return b & MEM_MASK;
	endfunction

endpackage

// ===== src/dmic_item_if.sv =====
`timescale 1ns / 1ps
// input channel of the instruction cache: valid, ready and item payload
// no dependencies

interface dmic_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] address;
	logic        cached;
	logic [31:0] fill_data;
	logic [8:0]  line_select;

	modport source (output valid, kind, address, cached, fill_data, line_select,
		input ready);
	modport sink (input valid, kind, address, cached, fill_data, line_select,
		output ready);
endinterface

// ===== src/dmic_result_if.sv =====
`timescale 1ns / 1ps
// result channel of the instruction cache: valid, ready and result payload
// no dependencies

interface dmic_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [31:0] result_address;
	logic [31:0] result_data;
	logic        hit;
	logic        last;

	modport source (output valid, result_kind, result_address, result_data, hit, last,
		input ready);
	modport sink (input valid, result_kind, result_address, result_data, hit, last,
		output ready);
endinterface

// ===== src/dmic_store.sv =====
`timescale 1ns / 1ps
// tag/valid memory and line data memory, one registered read port each
// depends on dmic_pkg

module dmic_store (
	input  logic                clk,
	input  dmic_pkg::store_req_t req,
	output dmic_pkg::store_rsp_t rsp
);
	import dmic_pkg::*;

	meta_t meta_mem [LINE_COUNT];
	row_t  data_mem [LINE_COUNT];

	always_ff @(posedge clk) begin
		if (req.meta_we) begin
			meta_mem[req.wr_idx] <= req.meta_wdata;
		end
		if (req.data_clr) begin
			data_mem[req.wr_idx] <= '0;
		end else if (req.data_we) begin
			data_mem[req.wr_idx][req.data_word] <= req.data_wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rsp.meta <= meta_mem[req.rd_idx];
			rsp.row  <= data_mem[req.rd_idx];
		end
	end

endmodule

// ===== src/dmic_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer of the instruction cache: clearing pass, lookup, line fill, writeback, result register
// depends on dmic_pkg, dmic_item_if, dmic_result_if

module dmic_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	dmic_item_if.sink           item,
	dmic_result_if.source       result,
	output dmic_pkg::store_req_t req,
	input  dmic_pkg::store_rsp_t rsp
);
	import dmic_pkg::*;

	state_t state_q, state_d;

	logic [INDEX_W-1:0] clr_idx_q;
	logic [WORD_W-1:0]  fill_pos_q;
	logic [WORD_W-1:0]  wb_cnt_q;
	logic [31:0]        pending_addr_q;
	logic [31:0]        fill_word_q;
	logic               out_valid_q;
	result_t            out_q;

	logic [1:0]  kind_q;
	logic [31:0] addr_q;
	logic        cached_q;
	logic [8:0]  sel_q;

	logic               item_ready;
	logic               item_fire;
	logic               out_free;
	logic               load_out;
	result_t            out_n;
	logic [INDEX_W-1:0] lk_idx;
	logic [INDEX_W-1:0] pend_idx;
	logic [WORD_W-1:0]  pend_word;
	logic [WORD_W-1:0]  wb_word;
	logic [31:0]        wb_base;
	logic               hit;
	logic               fill_beat;
	logic               fill_last;
	logic               clr_last;

	assign item_fire = item.valid && item_ready;
	assign out_free  = !out_valid_q || result.ready;
	assign lk_idx    = (kind_q == KIND_WRITEBACK) ? INDEX_W'(sel_q)
		: addr_q[OFFSET_W +: INDEX_W];
	assign pend_idx  = pending_addr_q[OFFSET_W +: INDEX_W];
	assign pend_word = pending_addr_q[2 +: WORD_W];
	assign hit       = rsp.meta.valid && (rsp.meta.tag == addr_q[31:TAG_LSB]);
	assign wb_word   = (state_q == ST_WB) ? wb_cnt_q : '0;
	assign wb_base   = line_base(rsp.meta.tag, lk_idx);
	assign fill_beat = (state_q == ST_FILL) && item_fire && (item.kind == KIND_FILL);
	assign fill_last = fill_pos_q == WORD_W'(WORDS_PER_LINE - 1);
	assign clr_last  = clr_idx_q == INDEX_W'(LINE_COUNT - 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_fire && (item.kind == KIND_FETCH || item.kind == KIND_WRITEBACK))
					state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (out_free) begin
					if (kind_q == KIND_WRITEBACK) state_d = ST_WB;
					else if (cached_q && !hit) state_d = ST_FILL;
					else state_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				if (fill_beat && fill_last) state_d = ST_IDLE;
			end
			ST_WB: begin
				if (out_free && wb_cnt_q == WORD_W'(WORDS_PER_LINE - 1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready = 1'b0;
		load_out   = 1'b0;
		out_n      = '0;
		req        = '0;
		unique case (state_q)
			ST_CLEAR: begin
				req.wr_idx   = clr_idx_q;
				req.meta_we  = 1'b1;
				req.data_clr = 1'b1;
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				req.rd_en  = item_fire &&
					(item.kind == KIND_FETCH || item.kind == KIND_WRITEBACK);
				req.rd_idx = (item.kind == KIND_WRITEBACK) ? INDEX_W'(item.line_select)
					: item.address[OFFSET_W +: INDEX_W];
			end
			ST_LOOKUP: begin
				if (out_free) begin
					load_out = 1'b1;
					if (kind_q == KIND_WRITEBACK) begin
						out_n.kind    = RES_WB_WORD;
						out_n.address = wb_base;
						out_n.data    = rsp.row[0];
					end else if (!cached_q) begin
						out_n.kind    = RES_READ_REQ;
						out_n.address = addr_q & MEM_MASK;
						out_n.last    = 1'b1;
					end else if (hit) begin
						out_n.kind    = RES_WORD;
						out_n.address = addr_q;
						out_n.data    = rsp.row[addr_q[2 +: WORD_W]];
						out_n.hit     = 1'b1;
						out_n.last    = 1'b1;
					end else begin
						out_n.kind       = RES_FILL_REQ;
						out_n.address    = line_base(addr_q[31:TAG_LSB], lk_idx);
						out_n.last       = 1'b1;
						req.meta_we      = 1'b1;
						req.wr_idx       = lk_idx;
						req.meta_wdata   = '{valid: 1'b1, tag: addr_q[31:TAG_LSB]};
					end
				end
			end
			ST_FILL: begin
				item_ready     = out_free;
				req.data_we    = fill_beat;
				req.wr_idx     = pend_idx;
				req.data_word  = fill_pos_q;
				req.data_wdata = item.fill_data;
				if (fill_beat && fill_last) begin
					load_out      = 1'b1;
					out_n.kind    = RES_WORD;
					out_n.address = pending_addr_q;
					out_n.data    = (fill_pos_q == pend_word) ? item.fill_data : fill_word_q;
					out_n.last    = 1'b1;
				end
			end
			ST_WB: begin
				if (out_free) begin
					load_out      = 1'b1;
					out_n.kind    = RES_WB_WORD;
					out_n.address = (wb_base | (32'(wb_word) << 2)) & MEM_MASK;
					out_n.data    = rsp.row[wb_word];
					out_n.last    = wb_word == WORD_W'(WORDS_PER_LINE - 1);
				end
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_idx_q      <= '0;
			out_valid_q    <= 1'b0;
			fill_pos_q     <= '0;
			wb_cnt_q       <= '0;
			pending_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			if (state_q == ST_LOOKUP && state_d == ST_FILL) begin
				pending_addr_q <= addr_q;
				fill_pos_q     <= '0;
			end else if (fill_beat) begin
				fill_pos_q <= fill_pos_q + 1'b1;
			end
			if (state_q == ST_LOOKUP && load_out) wb_cnt_q <= WORD_W'(1);
			else if (state_q == ST_WB && load_out) wb_cnt_q <= wb_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_fire) begin
			kind_q   <= item.kind;
			addr_q   <= item.address;
			cached_q <= item.cached;
			sel_q    <= item.line_select;
		end
		// keep the requested word as it streams past
		if (fill_beat && fill_pos_q == pend_word) fill_word_q <= item.fill_data;
		if (load_out) out_q <= out_n;
	end

	assign item.ready            = item_ready;
	assign result.valid          = out_valid_q;
	assign result.result_kind    = out_q.kind;
	assign result.result_address = out_q.address;
	assign result.result_data    = out_q.data;
	assign result.hit            = out_q.hit;
	assign result.last           = out_q.last;

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result register overwritten while held");

	a_fill_req_enters_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && out_n.kind == RES_FILL_REQ) |=> state_q == ST_FILL)
		else $error("fill request without pending fill");

	a_no_read_during_meta_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.meta_we && req.rd_en))
		else $error("tag read and write in the same cycle");

	a_wb_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB && load_out && out_n.last) |=> state_q == ST_IDLE)
		else $error("writeback run did not end on its last beat");

endmodule

// ===== src/direct_mapped_icache.sv =====
`timescale 1ns / 1ps
// direct-mapped instruction cache, top level
// depends on dmic_pkg, dmic_item_if, dmic_result_if, dmic_store, dmic_ctrl

// Direct-mapped instruction cache of LINE_COUNT lines of WORDS_PER_LINE words
// (512 x 8 x 32 bits). Tags/valid bits and line data sit in two memories,
// each with one write port and one registered read port. After reset a
// clearing pass writes every line, with no item accepted. A fetch or
// writeback starts its memory read in the cycle it is accepted. A fetch
// result is loaded into the output register from the lookup state once that
// register is free, and the next item can be taken once it is loaded.
// A writeback returns WORDS_PER_LINE beats, one per cycle while the result
// register is free, and blocks input until the last one is loaded. During a
// fill one fill word is taken per cycle while the result register is free;
// fetches and writebacks offered meanwhile are taken and dropped. One result
// register sits on the output, so a new item can be taken and read while the
// previous beat waits to be taken; any stall on the result side holds the
// next load back.

module direct_mapped_icache (
	input  logic          clk,
	input  logic          arst_n,
	dmic_item_if.sink     item,
	dmic_result_if.source result
);
	import dmic_pkg::*;

	store_req_t req;
	store_rsp_t rsp;

	dmic_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	dmic_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== tb/dmic_beat_checker.sv =====
`timescale 1ns / 1ps
// watches both channels of the instruction cache, tracks cache contents and compares result beats
// depends on dmic_pkg, dmic_item_if and dmic_result_if

module dmic_beat_checker (
	input  logic   clk,
	input  logic   arst_n,
	dmic_item_if   item_bus,
	dmic_result_if result_bus,
	output int     mismatches,
	output int     awaited
);
	import dmic_pkg::*;

	logic [31:0]      line_words [LINE_COUNT*WORDS_PER_LINE];
	logic [TAG_W-1:0] line_tags  [LINE_COUNT];
	logic             line_valid [LINE_COUNT];
	logic [31:0]      miss_address;
	int               fill_due;
	int               bad_count;
	result_t          pending_beats[$];

	function automatic logic [INDEX_W-1:0] index_of(input logic [31:0] a);
		return a[OFFSET_W +: INDEX_W];
	endfunction

	function automatic int word_slot(input logic [31:0] a);
		return int'(index_of(a)) * WORDS_PER_LINE + int'(a[2 +: WORD_W]);
	endfunction

	// memory address of a line, built from the tag held for it
	function automatic logic [31:0] line_addr(input logic [INDEX_W-1:0] idx);
		return ({line_tags[idx], {TAG_LSB{1'b0}}} | {idx, {OFFSET_W{1'b0}}}) & MEM_MASK;
	endfunction

	task automatic push_beat(input logic [1:0] k, input logic [31:0] a, input logic [31:0] d,
		input logic h, input logic l);
		result_t b;
		b.kind    = k;
		b.address = a;
		b.data    = d;
		b.hit     = h;
		b.last    = l;
		pending_beats.push_back(b);
	endtask

	task automatic apply_item(input logic [1:0] kind, input logic [31:0] addr,
		input logic cached, input logic [31:0] fdata, input logic [INDEX_W-1:0] sel);
		logic [INDEX_W-1:0] idx;
		logic [31:0]        base;
		if (kind == KIND_FILL) begin
			// fill words with no miss outstanding are dropped
			if (fill_due != 0) begin
				idx = index_of(miss_address);
				line_words[int'(idx) * WORDS_PER_LINE + (WORDS_PER_LINE - fill_due)] = fdata;
				fill_due--;
				if (fill_due == 0)
					push_beat(RES_WORD, miss_address, line_words[word_slot(miss_address)],
						1'b0, 1'b1);
			end
		end else if (fill_due == 0 && kind == KIND_FETCH) begin
			idx = index_of(addr);
			if (!cached) begin
				push_beat(RES_READ_REQ, addr & MEM_MASK, 32'h0, 1'b0, 1'b1);
			end else if (line_valid[idx] && line_tags[idx] == addr[31:TAG_LSB]) begin
				push_beat(RES_WORD, addr, line_words[word_slot(addr)], 1'b1, 1'b1);
			end else begin
				line_valid[idx] = 1'b1;
				line_tags[idx]  = addr[31:TAG_LSB];
				miss_address    = addr;
				fill_due        = WORDS_PER_LINE;
				push_beat(RES_FILL_REQ, line_addr(idx), 32'h0, 1'b0, 1'b1);
			end
		end else if (fill_due == 0 && kind == KIND_WRITEBACK) begin
			// valid bit plays no part here
			base = line_addr(sel);
			for (int k = 0; k < WORDS_PER_LINE; k++)
				push_beat(RES_WB_WORD, (base | 32'(k * 4)) & MEM_MASK,
					line_words[int'(sel) * WORDS_PER_LINE + k], 1'b0,
					k == WORDS_PER_LINE - 1);
		end
	endtask

	task automatic match_beat();
		result_t got;
		result_t want;
		got.kind    = result_bus.result_kind;
		got.address = result_bus.result_address;
		got.data    = result_bus.result_data;
		got.hit     = result_bus.hit;
		got.last    = result_bus.last;
		if (pending_beats.size() == 0) begin
			if (bad_count < 10)
				$display("%0t: unexpected beat kind %0d addr %h data %h hit %b last %b",
					$time, got.kind, got.address, got.data, got.hit, got.last);
			bad_count++;
		end else begin
			want = pending_beats.pop_front();
			if (got.kind !== want.kind || got.address !== want.address ||
				got.data !== want.data || got.hit !== want.hit || got.last !== want.last) begin
				if (bad_count < 10)
					$display("%0t: beat mismatch: expected kind %0d addr %h data %h hit %b last %b, got kind %0d addr %h data %h hit %b last %b",
						$time, want.kind, want.address, want.data, want.hit, want.last,
						got.kind, got.address, got.data, got.hit, got.last);
				bad_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_COUNT * WORDS_PER_LINE; i++)
				line_words[i] = 32'h0;
			for (int i = 0; i < LINE_COUNT; i++) begin
				line_tags[i]  = '0;
				line_valid[i] = 1'b0;
			end
			miss_address = 32'h0;
			fill_due     = 0;
			bad_count    = 0;
			pending_beats.delete();
			awaited    <= 0;
			mismatches <= 0;
		end else begin
			if (item_bus.valid && item_bus.ready)
				apply_item(item_bus.kind, item_bus.address, item_bus.cached,
					item_bus.fill_data, item_bus.line_select);
			if (result_bus.valid && result_bus.ready)
				match_beat();
			awaited    <= pending_beats.size();
			mismatches <= bad_count;
		end
	end

endmodule

// ===== tb/direct_mapped_icache_tb.sv =====
`timescale 1ns / 1ps
// top of the instruction cache testbench: clock, reset, fetch/fill/writeback stimulus, verdict
// depends on dmic_pkg, both channel interfaces, direct_mapped_icache and dmic_beat_checker

module direct_mapped_icache_tb;
	import dmic_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int ITEM_GOAL   = 330;
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 32;
	localparam int POOL_SIZE   = 24;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   awaited;
	int   hold_asks = 0;
	int   tx_quiet = 0;
	int   useful = 0;
	int   n_hits = 0;
	int   n_fills = 0;
	int   n_wb = 0;
	int   n_uncached = 0;
	int   n_ignored = 0;

	// which lines hold which tag, so misses can be followed by their fill words
	logic             known_valid [LINE_COUNT];
	logic [TAG_W-1:0] known_tag   [LINE_COUNT];
	logic [31:0]      hot_lines   [POOL_SIZE];

	dmic_item_if   item_bus ();
	dmic_result_if result_bus ();

	direct_mapped_icache DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus)
	);

	dmic_beat_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_bus   (item_bus),
		.result_bus (result_bus),
		.mismatches (fail_count),
		.awaited    (awaited)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// result side: random stalls, quiet stretches and the long hold-off on request
	initial begin
		int hold_served;
		int hold_left;
		int stall_left;
		int quiet_left;
		hold_served = 0;
		hold_left   = 0;
		stall_left  = 0;
		quiet_left  = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
				if (quiet_left > 0)
					quiet_left--;
				else begin
					stall_left = idle_len();
					if ($urandom_range(0, 49) == 0)
						quiet_left = $urandom_range(20, 60);
				end
			end
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [31:0] addr,
		input logic cached, input logic [31:0] fdata, input logic [8:0] sel);
		int gap;
		if (tx_quiet > 0) begin
			gap = 0;
			tx_quiet--;
		end else begin
			gap = idle_len();
			if ($urandom_range(0, 39) == 0)
				tx_quiet = $urandom_range(15, 40);
		end
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.kind        <= kind;
		item_bus.address     <= addr;
		item_bus.cached      <= cached;
		item_bus.fill_data   <= fdata;
		item_bus.line_select <= sel;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
	endtask

	task automatic issue_fetch(input logic [31:0] addr, input logic cached, output logic miss);
		logic [INDEX_W-1:0] idx;
		idx  = addr[OFFSET_W +: INDEX_W];
		miss = 1'b0;
		send_item(KIND_FETCH, addr, cached, $urandom, 9'($urandom));
		useful++;
		if (!cached)
			n_uncached++;
		else if (known_valid[idx] && known_tag[idx] == addr[31:TAG_LSB])
			n_hits++;
		else begin
			known_valid[idx] = 1'b1;
			known_tag[idx]   = addr[31:TAG_LSB];
			miss             = 1'b1;
		end
	endtask

	// beats the block takes and drops
	task automatic send_noise(input bit in_fill);
		logic [1:0] k;
		case ($urandom_range(0, 2))
			0: k = in_fill ? KIND_FETCH : KIND_FILL;
			1: k = in_fill ? KIND_WRITEBACK : KIND_FILL;
			default: k = KIND_SPARE;
		endcase
		send_item(k, $urandom, 1'($urandom), $urandom, 9'($urandom));
		n_ignored++;
	endtask

	task automatic fill_line(input int noise_pct, input bit extremes);
		logic [31:0] w;
		n_fills++;
		for (int k = 0; k < WORDS_PER_LINE; k++) begin
			if ($urandom_range(1, 100) <= noise_pct)
				send_noise(1'b1);
			w = extremes ? ((k % 2 != 0) ? 32'h0 : 32'hffff_ffff) : $urandom;
			send_item(KIND_FILL, $urandom, 1'($urandom), w, 9'($urandom));
			useful++;
		end
	endtask

	task automatic write_back(input logic [8:0] sel);
		send_item(KIND_WRITEBACK, $urandom, 1'($urandom), $urandom, sel);
		useful++;
		n_wb++;
	endtask

	task automatic drain();
		item_bus.valid <= 1'b0;
		do @(posedge clk); while (awaited != 0);
	endtask

	initial begin
		logic        miss;
		logic [31:0] a;
		int          r;
		arst_n               <= 1'b0;
		item_bus.valid       <= 1'b0;
		item_bus.kind        <= KIND_FETCH;
		item_bus.address     <= 32'h0;
		item_bus.cached      <= 1'b0;
		item_bus.fill_data   <= 32'h0;
		item_bus.line_select <= 9'h0;
		for (int i = 0; i < LINE_COUNT; i++) begin
			known_valid[i] = 1'b0;
			known_tag[i]   = '0;
		end
		// half the hot lines alias the other half: same index, different tag
		hot_lines[0] = 32'h0;
		for (int i = 1; i < POOL_SIZE / 2; i++)
			hot_lines[i] = $urandom & ~32'h1f;
		for (int i = POOL_SIZE / 2; i < POOL_SIZE; i++)
			hot_lines[i] = hot_lines[i - POOL_SIZE / 2] ^ {14'($urandom_range(1, 16383)), 18'h0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: invalid lines, uncached extremes, dropped beats, one full miss and fill
		write_back(9'h000);
		write_back(9'h1ff);
		issue_fetch(32'hffff_ffff, 1'b0, miss);
		issue_fetch(32'h0000_0000, 1'b0, miss);
		send_item(KIND_SPARE, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 9'h1ff);
		send_item(KIND_FILL, 32'h0, 1'b0, 32'hffff_ffff, 9'h0);
		n_ignored += 2;
		issue_fetch(32'hffff_fffe, 1'b1, miss);
		send_item(KIND_FETCH, 32'hffff_ffe0, 1'b1, 32'h0, 9'h0);
		send_item(KIND_WRITEBACK, 32'h0, 1'b0, 32'h0, 9'h1ff);
		send_item(KIND_SPARE, 32'h0, 1'b0, 32'h0, 9'h0);
		n_ignored += 3;
		fill_line(0, 1'b1);
		issue_fetch(32'hffff_ffe0, 1'b1, miss);
		write_back(9'h1ff);
		drain();

		// results held off while hits and writebacks keep coming
		hold_asks++;
		tx_quiet = 40;
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 2)
				write_back(9'h1ff);
			else
				issue_fetch(32'hffff_ffe0 | 32'((i % WORDS_PER_LINE) * 4), 1'b1, miss);
		end
		tx_quiet = 0;

		while (useful < ITEM_GOAL) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				a = hot_lines[$urandom_range(0, POOL_SIZE - 1)] | 32'($urandom_range(0, 31));
				issue_fetch(a, 1'b1, miss);
				if (miss)
					fill_line(12, 1'b0);
			end else if (r < 57) begin
				issue_fetch($urandom, 1'b1, miss);
				if (miss)
					fill_line(12, 1'b0);
			end else if (r < 71) begin
				issue_fetch($urandom, 1'b0, miss);
			end else if (r < 85) begin
				if ($urandom_range(0, 1) == 0)
					write_back(hot_lines[$urandom_range(0, POOL_SIZE - 1)][OFFSET_W +: INDEX_W]);
				else
					write_back(9'($urandom));
			end else if (r < 87) begin
				drain();
			end else begin
				send_noise(1'b0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d items: %0d hits, %0d line fills, %0d writebacks, %0d uncached",
			useful, n_hits, n_fills, n_wb, n_uncached);
		$display("%0d dropped beats offered, %0d result mismatches", n_ignored, fail_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
